/* src/bpm_pkg.sv */
package bpm_pkg;

   localparam int DEBOUNCE_WIDTH = 8;
   localparam int TICK_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET   = 8'd20;
   localparam logic [TICK_WIDTH-1:0]     LONG_PRESS_RESET = 16'd2000;
   localparam logic [TICK_WIDTH-1:0]     REVERT_RESET     = 16'd30000;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_REVERT     = 2'd2;

   localparam logic [1:0] ACT_NONE            = 2'd0;
   localparam logic [1:0] ACT_CHANGE_OVERRIDE = 2'd1;
   localparam logic [1:0] ACT_HOT_WATER       = 2'd2;

   typedef struct packed {
      logic [TICK_WIDTH-1:0]     revert_ticks;
      logic [TICK_WIDTH-1:0]     long_press_ticks;
      logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
   } cfg_type;

   // Packed so that action sits in the lowest bits.
   typedef struct packed {
      logic       long_now;
      logic       pressed_now;
      logic       override_mode;
      logic [1:0] action;
   } rsp_type;

endpackage

/* src/button_press_mode_controller.sv */
// Throughput: one tick beat per cycle while rsp_tready holds, set by the input register
// feeding a single pass of counter and flag logic into the result register; a beat in
// the input register waits there while the result register is full and not drained.
// Reset: synchronous, active high; the config registers return to their default values,
// the counters and flags clear and the mode bit is set.
module button_press_mode_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] pin_level
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] action, [2] override_mode, [3] pressed_now, [4] long_now
   output logic [7:0]                          rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpm_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [bpm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic             in_valid_ff;
   logic             pin_ff;
   logic             rsp_valid_ff;
   bpm_pkg::rsp_type rsp_ff;
   bpm_pkg::rsp_type step_result;
   bpm_pkg::cfg_type cfg;
   logic             advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   bpm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   bpm_step u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .pin_level (pin_ff),
      .cfg       (cfg),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pin_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

endmodule

/* src/bpm_csr.sv */
module bpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [bpm_pkg::CSR_IDX_WIDTH-1:0]    wr_index,
   input  logic [bpm_pkg::CSR_DATA_WIDTH-1:0]   wr_data,
   output bpm_pkg::cfg_type                     cfg
);

   bpm_pkg::cfg_type cfg_ff;
   bpm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            bpm_pkg::REG_DEBOUNCE: begin
               cfg_in.debounce_ticks = wr_data[bpm_pkg::DEBOUNCE_WIDTH-1:0];
            end
            bpm_pkg::REG_LONG_PRESS: begin
               cfg_in.long_press_ticks = wr_data[bpm_pkg::TICK_WIDTH-1:0];
            end
            bpm_pkg::REG_REVERT: begin
               cfg_in.revert_ticks = wr_data[bpm_pkg::TICK_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= bpm_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= bpm_pkg::LONG_PRESS_RESET;
         cfg_ff.revert_ticks     <= bpm_pkg::REVERT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/bpm_step.sv */
module bpm_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              pin_level,
   input  bpm_pkg::cfg_type  cfg,
   output bpm_pkg::rsp_type  result
);

   logic [bpm_pkg::DEBOUNCE_WIDTH-1:0] integ_ff, integ_in;
   logic                               pressed_ff, pressed_in;
   logic [bpm_pkg::TICK_WIDTH-1:0]     held_ff, held_in;
   logic [bpm_pkg::TICK_WIDTH-1:0]     idle_ff, idle_in;
   logic                               prev_pressed_ff;
   logic                               prev_long_ff;
   logic                               mode_ff, mode_in;
   logic                               is_long;
   logic [1:0]                         action;

   always_comb begin
      integ_in = integ_ff;
      if (pin_level) begin
         if (integ_ff < cfg.debounce_ticks) begin
            integ_in = integ_ff + 1'b1;
         end
      end else if (integ_ff != '0) begin
         integ_in = integ_ff - 1'b1;
      end

      pressed_in = pressed_ff;
      if (integ_in == '0) begin
         pressed_in = 1'b1;
      end else if (integ_in >= cfg.debounce_ticks) begin
         pressed_in = 1'b0;
      end

      if (pressed_in) begin
         held_in = (held_ff == bpm_pkg::TICK_MAX) ? held_ff : held_ff + 1'b1;
         idle_in = '0;
         is_long = (held_in >= cfg.long_press_ticks);
      end else begin
         held_in = '0;
         idle_in = (idle_ff == bpm_pkg::TICK_MAX) ? idle_ff : idle_ff + 1'b1;
         is_long = 1'b0;
      end

      mode_in = mode_ff;
      if (is_long && !prev_long_ff) begin
         mode_in = !mode_ff;
      end
      if (idle_in >= cfg.revert_ticks) begin
         mode_in = 1'b1;
      end

      action = bpm_pkg::ACT_NONE;
      if (!pressed_in && prev_pressed_ff && !prev_long_ff) begin
         action = mode_in ? bpm_pkg::ACT_CHANGE_OVERRIDE : bpm_pkg::ACT_HOT_WATER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff        <= '0;
         pressed_ff      <= 1'b0;
         held_ff         <= '0;
         idle_ff         <= '0;
         prev_pressed_ff <= 1'b0;
         prev_long_ff    <= 1'b0;
         mode_ff         <= 1'b1;
      end else if (step_en) begin
         integ_ff        <= integ_in;
         pressed_ff      <= pressed_in;
         held_ff         <= held_in;
         idle_ff         <= idle_in;
         prev_pressed_ff <= pressed_in;
         prev_long_ff    <= is_long;
         mode_ff         <= mode_in;
      end
   end

   assign result.action        = action;
   assign result.override_mode = mode_in;
   assign result.pressed_now   = pressed_in;
   assign result.long_now      = is_long;

endmodule

/* tb/tb_button_press_mode_controller.sv */
`timescale 1ns / 1ps

module tb_button_press_mode_controller;

   localparam logic [bpm_pkg::CSR_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [7:0]                         rsp_tdata;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [bpm_pkg::CSR_IDX_WIDTH-1:0]  csr_index  = '0;
   logic [bpm_pkg::CSR_DATA_WIDTH-1:0] csr_data   = '0;

   int gap_pct     = 0;
   int stall_pct   = 0;
   int error_count = 0;

   bpm_pkg::cfg_type cfg = '{revert_ticks: bpm_pkg::REVERT_RESET,
                             long_press_ticks: bpm_pkg::LONG_PRESS_RESET,
                             debounce_ticks: bpm_pkg::DEBOUNCE_RESET};

   logic [bpm_pkg::DEBOUNCE_WIDTH-1:0] integ        = '0;
   logic                               pressed      = 1'b0;
   logic [bpm_pkg::TICK_WIDTH-1:0]     held         = '0;
   logic [bpm_pkg::TICK_WIDTH-1:0]     idle         = '0;
   logic                               prev_pressed = 1'b0;
   logic                               prev_long    = 1'b0;
   logic                               mode         = 1'b1;

   bpm_pkg::rsp_type expected_status[$];

   button_press_mode_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic bpm_pkg::rsp_type step_button(logic pin);
      bpm_pkg::rsp_type r;
      logic             is_long;
      if (pin) begin
         if (integ < cfg.debounce_ticks) integ = integ + 8'd1;
      end else if (integ != '0) begin
         integ = integ - 8'd1;
      end
      if (integ >= cfg.debounce_ticks) pressed = 1'b0;
      if (integ == '0) pressed = 1'b1;
      if (pressed) begin
         if (held != bpm_pkg::TICK_MAX) held = held + 16'd1;
         idle    = '0;
         is_long = (held >= cfg.long_press_ticks);
      end else begin
         held = '0;
         if (idle != bpm_pkg::TICK_MAX) idle = idle + 16'd1;
         is_long = 1'b0;
      end
      if (is_long && !prev_long) mode = ~mode;
      if (idle >= cfg.revert_ticks) mode = 1'b1;
      r.action = bpm_pkg::ACT_NONE;
      if (!pressed && prev_pressed && !prev_long)
         r.action = mode ? bpm_pkg::ACT_CHANGE_OVERRIDE : bpm_pkg::ACT_HOT_WATER;
      r.override_mode = mode;
      r.pressed_now   = pressed;
      r.long_now      = is_long;
      prev_pressed    = pressed;
      prev_long       = is_long;
      return r;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      bpm_pkg::rsp_type got;
      bpm_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = bpm_pkg::rsp_type'(rsp_tdata[4:0]);
         if (expected_status.size() == 0) begin
            $error("result beat with no tick pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            compare_field("action", 32'(want.action), 32'(got.action));
            compare_field("override_mode", 32'(want.override_mode), 32'(got.override_mode));
            compare_field("pressed_now", 32'(want.pressed_now), 32'(got.pressed_now));
            compare_field("long_now", 32'(want.long_now), 32'(got.long_now));
         end
      end
   end

   task automatic send_tick(logic pin);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'($urandom), pin};
      do @(posedge clock); while (!req_tready);
      expected_status.push_back(step_button(pin));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [bpm_pkg::CSR_IDX_WIDTH-1:0] idx,
                            logic [bpm_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bpm_pkg::REG_DEBOUNCE:
            cfg.debounce_ticks = value[bpm_pkg::DEBOUNCE_WIDTH-1:0];
         bpm_pkg::REG_LONG_PRESS: cfg.long_press_ticks = value;
         bpm_pkg::REG_REVERT:     cfg.revert_ticks     = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(int deb, int lp, int rv);
      write_reg(bpm_pkg::REG_DEBOUNCE, {8'($urandom), 8'(deb)});
      write_reg(bpm_pkg::REG_LONG_PRESS, 16'(lp));
      write_reg(bpm_pkg::REG_REVERT, 16'(rv));
   endtask

   task automatic test_zero_settings();
      settle();
      write_reg(REG_UNUSED, 16'($urandom));
      set_timing(0, 0, 0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_short_long_press();
      settle();
      set_timing(1, 3, 65535);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_debounce_lowered();
      settle();
      set_timing(3, 2, 2);
      repeat (3) send_tick(1'b1);
      settle();
      write_reg(bpm_pkg::REG_DEBOUNCE, {8'($urandom), 8'd1});
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
   endtask

   task automatic test_random_presses(int n_items, int variant);
      int   deb;
      int   lp;
      int   rv;
      int   sent;
      int   span;
      int   rl;
      bit   paused;
      logic level;
      for (int s = 0; s < 2; s++) begin
         settle();
         if (variant == 1 && s == 1) begin
            deb = 1;
            lp  = 1;
            rv  = 1;
         end else if (variant == 2 && s == 1) begin
            deb = 255;
            lp  = 65535;
            rv  = 65535;
         end else begin
            deb = $urandom_range(1, 6);
            lp  = $urandom_range(1, 40);
            rv  = $urandom_range(1, 80);
         end
         set_timing(deb, lp, rv);
         sent   = 0;
         paused = 0;
         level  = 1'b1;
         while (sent < n_items / 2) begin
            span = (level ? rv : lp) + 2 * deb + 4;
            if (span > 300) span = 300;
            rl = $urandom_range(1, span);
            if (rl > n_items / 2 - sent) rl = n_items / 2 - sent;
            if ($urandom_range(9) == 0) begin
               for (int k = 0; k < rl; k++) send_tick(1'($urandom));
            end else begin
               for (int k = 0; k < rl; k++) begin
                  if ($urandom_range(99) < 8) send_tick(~level);
                  else send_tick(level);
               end
            end
            sent += rl;
            level = ~level;
            if (!paused && sent >= n_items / 4) begin
               settle();
               paused = 1;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      gap_pct   = 26;
      stall_pct = 61;
      test_zero_settings();
      test_short_long_press();
      test_debounce_lowered();
      test_random_presses(350, 0);
      settle();
      gap_pct   = 61;
      stall_pct = 26;
      test_random_presses(350, 1);
      settle();
      gap_pct   = 0;
      stall_pct = 0;
      test_random_presses(350, 2);
      settle();
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
src/bpm_pkg.sv
src/bpm_csr.sv
src/bpm_step.sv
src/button_press_mode_controller.sv
tb/tb_button_press_mode_controller.sv
